### rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the rgb/hsv converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CompBits   = 8;
	localparam int CompMax    = (1 << CompBits) - 1;
	localparam int HueSubBits = 6;
	localparam int HueTurn    = 360 << HueSubBits;
	localparam int HueSector  = 60 << HueSubBits;
	localparam int HueInBits  = 16;
	localparam int HueBits    = 15;
	localparam int FracBits   = 12;
	localparam int SectBits   = 3;

	// divider lanes: numerator, denominator, quotient widths
	localparam int Lanes  = 2;
	localparam int NumW   = 28;
	localparam int DenW   = 20;
	localparam int QuotW  = 15;
	localparam int RgbDen = CompMax * HueSector;
	localparam int RgbHalf = RgbDen / 2;

	// request kinds
	localparam logic ReqHsvToRgb = 1'b0;
	localparam logic ReqRgbToHsv = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [CompBits-1:0]   in_red;
		logic [CompBits-1:0]   in_green;
		logic [CompBits-1:0]   in_blue;
		logic [HueInBits-1:0]  in_hue;
		logic [CompBits-1:0]   in_saturation;
		logic [CompBits-1:0]   in_value;
	} req_t;

	typedef struct packed {
		logic [CompBits-1:0]   out_red;
		logic [CompBits-1:0]   out_green;
		logic [CompBits-1:0]   out_blue;
		logic [HueBits-1:0]    out_hue;
		logic [CompBits-1:0]   out_saturation;
		logic [CompBits-1:0]   out_value;
	} rsp_t;

	// side information that travels beside the dividers
	typedef struct packed {
		logic                  rgb_mode;
		logic                  zero_delta;
		logic [SectBits-1:0]   sector;
		logic [CompBits-1:0]   val;
		logic [CompBits-1:0]   tval;
	} meta_t;

	typedef logic [Lanes-1:0][NumW-1:0]  num_vec_t;
	typedef logic [Lanes-1:0][DenW-1:0]  den_vec_t;
	typedef logic [Lanes-1:0][QuotW-1:0] quot_vec_t;

endpackage

### rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Three stages that form the rounded numerators and denominators.
// ----------------------------------------------------------------------------
module rhc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             req_valid,
	input  rhc_pkg::req_t    req,
	output logic             valid_s3,
	output rhc_pkg::num_vec_t num_s3,
	output rhc_pkg::den_vec_t den_s3,
	output rhc_pkg::meta_t   meta_s3
);

	localparam int CW = rhc_pkg::CompBits;
	localparam int TotW = 23;
	localparam logic [1:0] SelRed   = 2'd0;
	localparam logic [1:0] SelGreen = 2'd1;
	localparam logic [1:0] SelBlue  = 2'd2;
	// the t divisor is 256 * 3825; 3825 is handled by ceil(2^32 / 3825)
	localparam int TShift = 32;
	localparam logic [20:0] TRecip = 21'd1122868;

	// stage 1 signals
	logic [rhc_pkg::HueBits-1:0]  hue_c;
	logic [rhc_pkg::SectBits-1:0] sect_c;
	logic [rhc_pkg::FracBits-1:0] frac_c;
	logic [CW-1:0] mx_c, mn_c;
	logic [1:0] sel_c;

	logic valid_s1, mode_s1;
	logic [rhc_pkg::SectBits-1:0] sector_s1;
	logic [CW-1:0] val_s1, delta_s1, r_s1, g_s1, b_s1;
	logic [1:0] sel_s1;
	logic [2*CW-1:0] vs_s1;
	logic [19:0] sf_s1, st_s1;

	logic valid_s2, mode_s2, zero_s2;
	logic [rhc_pkg::SectBits-1:0] sector_s2;
	logic [CW-1:0] val_s2, delta_s2;
	logic [16:0] pn_s2, satn_s2;
	logic [rhc_pkg::NumW-1:0] qm_s2, tm_s2;
	logic [TotW-1:0] total_s2, total_c;

	// stage 3 t quotient
	logic [rhc_pkg::NumW-1:0] tn_c;
	logic [19:0] tq_c;
	logic [40:0] tp_c;

	// hue clamp, sector and fraction, max and min
	always_comb begin
		hue_c = (req.in_hue >= 16'(rhc_pkg::HueTurn)) ? '0 : req.in_hue[rhc_pkg::HueBits-1:0];
		if (hue_c < 15'(rhc_pkg::HueSector)) sect_c = 3'd0;
		else if (hue_c < 15'(2*rhc_pkg::HueSector)) sect_c = 3'd1;
		else if (hue_c < 15'(3*rhc_pkg::HueSector)) sect_c = 3'd2;
		else if (hue_c < 15'(4*rhc_pkg::HueSector)) sect_c = 3'd3;
		else if (hue_c < 15'(5*rhc_pkg::HueSector)) sect_c = 3'd4;
		else sect_c = 3'd5;
		frac_c = 12'(hue_c - 15'(sect_c * 15'(rhc_pkg::HueSector)));
		sel_c = SelRed;
		mx_c = req.in_red;
		if (req.in_green > mx_c) begin
			mx_c = req.in_green;
			sel_c = SelGreen;
		end
		if (req.in_blue > mx_c) begin
			mx_c = req.in_blue;
			sel_c = SelBlue;
		end
		mn_c = req.in_red;
		if (req.in_green < mn_c) mn_c = req.in_green;
		if (req.in_blue < mn_c) mn_c = req.in_blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= req.req_type;
			sector_s1 <= sect_c;
			val_s1    <= (req.req_type == rhc_pkg::ReqRgbToHsv) ? mx_c : req.in_value;
			delta_s1  <= mx_c - mn_c;
			r_s1      <= req.in_red;
			g_s1      <= req.in_green;
			b_s1      <= req.in_blue;
			sel_s1    <= sel_c;
			vs_s1     <= req.in_value * (8'(rhc_pkg::CompMax) - req.in_saturation);
			sf_s1     <= 20'(req.in_saturation) * 20'(frac_c);
			st_s1     <= 20'(req.in_saturation) * 20'(12'(rhc_pkg::HueSector) - frac_c);
		end
	end

	// hue numerator by dominant component
	always_comb begin
		case (sel_s1)
			SelRed:
				total_c = (g_s1 >= b_s1)
					? 23'((g_s1 - b_s1) * 23'(rhc_pkg::HueSector))
					: 23'(delta_s1 * 23'(rhc_pkg::HueTurn) - (b_s1 - g_s1) * 23'(rhc_pkg::HueSector));
			SelGreen:
				total_c = (b_s1 >= r_s1)
					? 23'(delta_s1 * 23'(2*rhc_pkg::HueSector) + (b_s1 - r_s1) * 23'(rhc_pkg::HueSector))
					: 23'(delta_s1 * 23'(2*rhc_pkg::HueSector) - (r_s1 - b_s1) * 23'(rhc_pkg::HueSector));
			default:
				total_c = (r_s1 >= g_s1)
					? 23'(delta_s1 * 23'(4*rhc_pkg::HueSector) + (r_s1 - g_s1) * 23'(rhc_pkg::HueSector))
					: 23'(delta_s1 * 23'(4*rhc_pkg::HueSector) - (g_s1 - r_s1) * 23'(rhc_pkg::HueSector));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2   <= mode_s1;
			zero_s2   <= (delta_s1 == '0);
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			delta_s2  <= delta_s1;
			pn_s2     <= 17'(vs_s1) + 17'(rhc_pkg::CompMax / 2);
			qm_s2     <= 28'(val_s1) * 28'(20'(rhc_pkg::RgbDen) - sf_s1);
			tm_s2     <= 28'(val_s1) * 28'(20'(rhc_pkg::RgbDen) - st_s1);
			satn_s2   <= 17'(delta_s1) * 17'(rhc_pkg::CompMax) + 17'(val_s1 >> 1);
			total_s2  <= total_c;
		end
	end

	// rounded t: drop the power-of-two part of the divisor, then scale by the reciprocal
	always_comb begin
		tn_c = tm_s2 + 28'(rhc_pkg::RgbHalf);
		tq_c = tn_c[rhc_pkg::NumW-1:8];
		tp_c = 41'(tq_c) * 41'(TRecip);
	end

	// rounding offsets and lane selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mode_s2 == rhc_pkg::ReqRgbToHsv) begin
				num_s3[0] <= 28'(satn_s2);
				den_s3[0] <= 20'(val_s2);
				num_s3[1] <= 28'(total_s2) + 28'(delta_s2 >> 1);
				den_s3[1] <= 20'(delta_s2);
			end else begin
				num_s3[0] <= 28'(pn_s2);
				den_s3[0] <= 20'(rhc_pkg::CompMax);
				num_s3[1] <= qm_s2 + 28'(rhc_pkg::RgbHalf);
				den_s3[1] <= 20'(rhc_pkg::RgbDen);
			end
			meta_s3.rgb_mode   <= mode_s2;
			meta_s3.zero_delta <= zero_s2;
			meta_s3.sector     <= sector_s2;
			meta_s3.val        <= val_s2;
			meta_s3.tval       <= tp_c[TShift+CW-1:TShift];
		end
	end

endmodule

### rtl/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module rhc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  rhc_pkg::num_vec_t num,
	input  rhc_pkg::den_vec_t den,
	input  rhc_pkg::meta_t    meta_in,
	output logic              valid_out,
	output rhc_pkg::quot_vec_t quot,
	output rhc_pkg::meta_t    meta_out
);

	localparam int Steps = rhc_pkg::QuotW;
	localparam int ShW   = rhc_pkg::DenW + rhc_pkg::QuotW;

	logic [Steps-1:0]    valid_s;
	rhc_pkg::num_vec_t   rem_s  [Steps];
	rhc_pkg::den_vec_t   den_s  [Steps];
	rhc_pkg::quot_vec_t  quot_s [Steps];
	rhc_pkg::meta_t      meta_s [Steps];

	for (genvar j = 0; j < Steps; j++) begin : g_step
		localparam int K = Steps - 1 - j;
		logic               vin;
		rhc_pkg::num_vec_t  rin;
		rhc_pkg::den_vec_t  din;
		rhc_pkg::quot_vec_t qin;
		rhc_pkg::meta_t     min_w;
		rhc_pkg::num_vec_t  rnx;
		rhc_pkg::quot_vec_t qnx;

		if (j == 0) begin : g_first
			assign vin   = valid_in;
			assign rin   = num;
			assign din   = den;
			assign qin   = '0;
			assign min_w = meta_in;
		end else begin : g_next
			assign vin   = valid_s[j-1];
			assign rin   = rem_s[j-1];
			assign din   = den_s[j-1];
			assign qin   = quot_s[j-1];
			assign min_w = meta_s[j-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			logic [ShW-1:0] dsh;
			logic ge;
			rnx = rin;
			qnx = qin;
			for (int l = 0; l < rhc_pkg::Lanes; l++) begin
				dsh = ShW'(din[l]) << K;
				ge  = ShW'(rin[l]) >= dsh;
				if (ge) rnx[l] = rin[l] - dsh[rhc_pkg::NumW-1:0];
				qnx[l][K] = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j] <= 1'b0;
			else if (en) valid_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rnx;
				den_s[j]  <= din;
				quot_s[j] <= qnx;
				meta_s[j] <= min_w;
			end
		end
	end

	assign valid_out = valid_s[Steps-1];
	assign quot      = quot_s[Steps-1];
	assign meta_out  = meta_s[Steps-1];

endmodule

### rtl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Sector assignment, hue wrap and the output register.
// ----------------------------------------------------------------------------
module rhc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  rhc_pkg::quot_vec_t quot,
	input  rhc_pkg::meta_t     meta,
	output logic               rsp_valid,
	output rhc_pkg::rsp_t      rsp
);

	localparam int CW = rhc_pkg::CompBits;

	rhc_pkg::rsp_t rsp_c;
	logic [CW-1:0] p_c, q_c, t_c, v_c;

	// pick p, q and t by sector, or build the hsv result
	always_comb begin
		p_c = quot[0][CW-1:0];
		q_c = quot[1][CW-1:0];
		t_c = meta.tval;
		v_c = meta.val;
		rsp_c = '0;
		if (meta.rgb_mode == rhc_pkg::ReqRgbToHsv) begin
			rsp_c.out_value = v_c;
			if (!meta.zero_delta) begin
				rsp_c.out_saturation = p_c;
				rsp_c.out_hue = (quot[1] >= 15'(rhc_pkg::HueTurn))
					? quot[1] - 15'(rhc_pkg::HueTurn) : quot[1];
			end
		end else begin
			case (meta.sector)
				3'd0: begin rsp_c.out_red = v_c; rsp_c.out_green = t_c; rsp_c.out_blue = p_c; end
				3'd1: begin rsp_c.out_red = q_c; rsp_c.out_green = v_c; rsp_c.out_blue = p_c; end
				3'd2: begin rsp_c.out_red = p_c; rsp_c.out_green = v_c; rsp_c.out_blue = t_c; end
				3'd3: begin rsp_c.out_red = p_c; rsp_c.out_green = q_c; rsp_c.out_blue = v_c; end
				3'd4: begin rsp_c.out_red = t_c; rsp_c.out_green = p_c; rsp_c.out_blue = v_c; end
				default: begin rsp_c.out_red = v_c; rsp_c.out_green = p_c; rsp_c.out_blue = q_c; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (en) rsp_valid <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) rsp <= rsp_c;
	end

endmodule

### rtl/rgb_hsv_converter.sv
// Stages: an accepted request passes through 3 front stages, 15 divider stages
// and one output register, in that order.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a result waits at the output.
// Reset: asynchronous, clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_hsv_converter
// Pipelined converter between rgb and hsv, direction chosen per request.
// ----------------------------------------------------------------------------
module rgb_hsv_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rhc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rhc_pkg::rsp_t rsp
);

	logic               en;
	logic               valid_s3, div_valid;
	rhc_pkg::num_vec_t  num_s3;
	rhc_pkg::den_vec_t  den_s3;
	rhc_pkg::meta_t     meta_s3, div_meta;
	rhc_pkg::quot_vec_t div_quot;

	// advance whenever the output slot is free or being taken
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	rhc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .req_valid(req_valid), .req(req),
		.valid_s3(valid_s3), .num_s3(num_s3), .den_s3(den_s3), .meta_s3(meta_s3)
	);

	rhc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(valid_s3),
		.num(num_s3), .den(den_s3), .meta_in(meta_s3),
		.valid_out(div_valid), .quot(div_quot), .meta_out(div_meta)
	);

	rhc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(div_valid),
		.quot(div_quot), .meta(div_meta), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	// hue always lands inside one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_hue < 15'(rhc_pkg::HueTurn))
		else $error("hue out of range");

	// zero saturation only comes with zero hue
	a_sat_hue: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_saturation == '0 |-> rsp.out_hue == '0)
		else $error("hue set with zero saturation");

	// a stalled result blocks new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken during stall");

endmodule
